>>> rtl/core/canonical_huffman_bit_decoder_assert.svh
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_ASSERT_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/chb_pkg.sv
package chb_pkg;

    localparam int MAX_CODE_LENGTH_DEF = 16;
    localparam int MAX_SYMBOLS_DEF     = 256;

    localparam int CODE_W  = 16;  // partial code
    localparam int RANGE_W = 17;  // first code and range end
    localparam int BCODE_W = 18;  // running code during build
    localparam int OFF_W   = 9;   // value offset
    localparam int SUM_W   = 12;  // sum of up to 16 counts
    localparam int TAKEN_W = 5;   // bits taken, up to 16

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_APPEND = 3'd2;
    localparam logic [2:0] CMD_BUILD  = 3'd3;
    localparam logic [2:0] CMD_DECODE = 3'd4;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NOT_BUILT = 3'd1;
    localparam logic [2:0] STS_MISMATCH  = 3'd2;
    localparam logic [2:0] STS_OVERSUB   = 3'd3;
    localparam logic [2:0] STS_BAD_PATH  = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] length_index;
        logic [7:0] count;
        logic [7:0] symbol_in;
        logic       bit_req;
    } t_chb_in;

    typedef struct packed {
        logic       symbol_valid;
        logic [7:0] symbol;
        logic [2:0] status;
    } t_chb_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_BFIN,
        S_SYM
    } t_chb_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic build_step;
        logic build_fin;
        logic sym_emit;
    } t_chb_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_build;
        logic hit;
        logic build_last;
    } t_chb_sts;

endpackage

>>> rtl/core/chb_dpath.sv
module chb_dpath #(
    parameter int MAX_CODE_LENGTH = chb_pkg::MAX_CODE_LENGTH_DEF,
    parameter int MAX_SYMBOLS     = chb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  chb_pkg::t_chb_in i_in_data,
    input  chb_pkg::t_chb_ctl i_ctl,
    output chb_pkg::t_chb_sts o_sts,
    output chb_pkg::t_chb_out o_out_data
);

    localparam int LW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int NW = $clog2(MAX_SYMBOLS + 1);
    localparam int CW = chb_pkg::CODE_W;
    localparam int RW = chb_pkg::RANGE_W;
    localparam int BW = chb_pkg::BCODE_W;
    localparam int OW = chb_pkg::OFF_W;
    localparam int SW = chb_pkg::SUM_W;
    localparam int TW = chb_pkg::TAKEN_W;

    // set-up and walk state
    logic [7:0]    r_counts [MAX_CODE_LENGTH];
    logic [NW-1:0] r_loaded;
    logic          r_built;
    logic [CW-1:0] r_partial;
    logic [TW-1:0] r_taken;
    logic [TW-1:0] r_lmax;
    logic [RW-1:0] r_end_max;

    // canonical tables
    logic [RW-1:0] r_first [MAX_CODE_LENGTH];
    logic [OW-1:0] r_off   [MAX_CODE_LENGTH];
    logic [RW-1:0] r_end   [MAX_CODE_LENGTH];

    // build iteration
    logic [LW-1:0] r_bi;
    logic [SW-1:0] r_sum;
    logic [BW-1:0] r_code;
    logic [OW-1:0] r_boff;
    logic          r_oversub;

    logic [7:0]    r_mem [MAX_SYMBOLS];
    logic [7:0]    r_rd;
    chb_pkg::t_chb_out r_out;

    logic [CW-1:0] w_partial;
    logic [TW-1:0] w_taken;
    logic [LW-1:0] w_li;
    logic          w_over;
    logic          w_in_range;
    logic [TW-1:0] w_gap;
    logic [RW-1:0] w_shift;
    logic          w_prefix;
    logic          w_hit;
    logic [RW-1:0] w_diff;
    logic [RW-1:0] w_sidx;
    logic [AW-1:0] w_idx;
    logic          w_full;
    logic          w_load_ok;
    logic [2:0]    w_status;
    logic [7:0]    w_bcnt;
    logic [BW-1:0] w_bend;
    logic [LW:0]   w_bsh;
    logic [BW-1:0] w_limit;
    logic [2:0]    w_bstatus;

    assign w_partial  = {r_partial[CW-2:0], i_in_data.bit_req};
    assign w_taken    = r_taken + TW'(1);
    assign w_li       = r_taken[LW-1:0];
    assign w_over     = (r_lmax == '0) || (w_taken > r_lmax);
    assign w_in_range = ({1'b0, w_partial} >= r_first[w_li]) &&
                        ({1'b0, w_partial} < r_end[w_li]);
    assign w_gap      = r_lmax - w_taken;
    assign w_shift    = {1'b0, w_partial} << w_gap[3:0];
    assign w_prefix   = w_shift < r_end_max;
    assign w_hit      = (i_in_data.cmd == chb_pkg::CMD_DECODE) && r_built &&
                        !w_over && w_in_range;
    assign w_diff     = {1'b0, w_partial} - r_first[w_li];
    assign w_sidx     = RW'(r_off[w_li]) + w_diff;
    assign w_idx      = w_sidx[AW-1:0];
    assign w_full     = r_loaded >= NW'(MAX_SYMBOLS);
    assign w_load_ok  = {1'b0, i_in_data.length_index} < 5'(MAX_CODE_LENGTH);

    assign w_bcnt  = r_counts[r_bi];
    assign w_bend  = r_code + BW'(w_bcnt);
    assign w_bsh   = {1'b0, r_bi} + (LW+1)'(1);
    assign w_limit = BW'(1) << w_bsh;

    assign o_sts.is_build   = i_in_data.cmd == chb_pkg::CMD_BUILD;
    assign o_sts.hit        = w_hit;
    assign o_sts.build_last = r_bi == LW'(MAX_CODE_LENGTH - 1);

    always_comb begin
        w_status = chb_pkg::STS_OK;
        if (i_in_data.cmd == chb_pkg::CMD_APPEND && w_full) begin
            w_status = chb_pkg::STS_MISMATCH;
        end else if (i_in_data.cmd == chb_pkg::CMD_DECODE) begin
            priority if (!r_built) begin
                w_status = chb_pkg::STS_NOT_BUILT;
            end else if (w_over) begin
                w_status = chb_pkg::STS_BAD_PATH;
            end else if (w_in_range || w_prefix) begin
                w_status = chb_pkg::STS_OK;
            end else begin
                w_status = chb_pkg::STS_BAD_PATH;
            end
        end
    end

    always_comb begin
        priority if (r_sum != SW'(r_loaded)) begin
            w_bstatus = chb_pkg::STS_MISMATCH;
        end else if (r_oversub) begin
            w_bstatus = chb_pkg::STS_OVERSUB;
        end else begin
            w_bstatus = chb_pkg::STS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                r_counts[i] <= '0;
            end
            r_loaded  <= '0;
            r_built   <= 1'b0;
            r_partial <= '0;
            r_taken   <= '0;
            r_lmax    <= '0;
            r_end_max <= '0;
            r_bi      <= '0;
            r_sum     <= '0;
            r_code    <= '0;
            r_boff    <= '0;
            r_oversub <= 1'b0;
        end else if (i_ctl.take) begin
            unique case (i_in_data.cmd)
                chb_pkg::CMD_CLEAR: begin
                    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                        r_counts[i] <= '0;
                    end
                    r_loaded  <= '0;
                    r_built   <= 1'b0;
                    r_partial <= '0;
                    r_taken   <= '0;
                end
                chb_pkg::CMD_LOAD: begin
                    if (w_load_ok) begin
                        r_counts[i_in_data.length_index[LW-1:0]] <= i_in_data.count;
                        r_built   <= 1'b0;
                        r_partial <= '0;
                        r_taken   <= '0;
                    end
                end
                chb_pkg::CMD_APPEND: begin
                    if (!w_full) begin
                        r_loaded  <= r_loaded + NW'(1);
                        r_built   <= 1'b0;
                        r_partial <= '0;
                        r_taken   <= '0;
                    end
                end
                chb_pkg::CMD_BUILD: begin
                    r_built   <= 1'b0;
                    r_partial <= '0;
                    r_taken   <= '0;
                    r_lmax    <= '0;
                    r_end_max <= '0;
                    r_bi      <= '0;
                    r_sum     <= '0;
                    r_code    <= '0;
                    r_boff    <= '0;
                    r_oversub <= 1'b0;
                end
                chb_pkg::CMD_DECODE: begin
                    if (r_built) begin
                        // keep walking only while still a prefix of a longer code
                        if (w_over || w_in_range || !w_prefix) begin
                            r_partial <= '0;
                            r_taken   <= '0;
                        end else begin
                            r_partial <= w_partial;
                            r_taken   <= w_taken;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (i_ctl.build_step) begin
            r_bi   <= r_bi + LW'(1);
            r_sum  <= r_sum + SW'(w_bcnt);
            r_boff <= r_boff + OW'(w_bcnt);
            r_code <= w_bend << 1;
            if (!r_oversub && w_bend > w_limit) begin
                r_oversub <= 1'b1;
            end
            if (w_bcnt != '0) begin
                r_lmax    <= TW'(w_bsh);
                r_end_max <= w_bend[RW-1:0];
            end
        end else if (i_ctl.build_fin) begin
            r_built <= w_bstatus == chb_pkg::STS_OK;
        end
    end

    // tables past an oversubscribed length are never used
    always_ff @(posedge i_clk) begin
        if (i_ctl.build_step && !r_oversub) begin
            r_first[r_bi] <= r_code[RW-1:0];
            r_off[r_bi]   <= r_boff;
            r_end[r_bi]   <= w_bend[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            if (i_in_data.cmd == chb_pkg::CMD_APPEND && !w_full) begin
                r_mem[r_loaded[AW-1:0]] <= i_in_data.symbol_in;
            end
            r_rd <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take && !o_sts.is_build && !w_hit) begin
            r_out.symbol_valid <= 1'b0;
            r_out.symbol       <= '0;
            r_out.status       <= w_status;
        end else if (i_ctl.build_fin) begin
            r_out.symbol_valid <= 1'b0;
            r_out.symbol       <= '0;
            r_out.status       <= w_bstatus;
        end else if (i_ctl.sym_emit) begin
            r_out.symbol_valid <= 1'b1;
            r_out.symbol       <= r_rd;
            r_out.status       <= chb_pkg::STS_OK;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/core/chb_ctrl.sv
module chb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  chb_pkg::t_chb_sts i_sts,
    output chb_pkg::t_chb_ctl o_ctl
);

    chb_pkg::t_chb_state r_state;
    chb_pkg::t_chb_state n_state;
    logic                r_ov;
    logic                n_ov;
    logic                w_free;
    logic                w_load;

    // output register can take a word this cycle
    assign w_free = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chb_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        w_load  = 1'b0;
        unique case (r_state)
            chb_pkg::S_IDLE: begin
                if (i_in_valid && w_free) begin
                    o_ctl.take = 1'b1;
                    priority if (i_sts.is_build) begin
                        n_state = chb_pkg::S_BUILD;
                    end else if (i_sts.hit) begin
                        n_state = chb_pkg::S_SYM;
                    end else begin
                        w_load = 1'b1;
                    end
                end
            end
            chb_pkg::S_BUILD: begin
                o_ctl.build_step = 1'b1;
                if (i_sts.build_last) begin
                    n_state = chb_pkg::S_BFIN;
                end
            end
            chb_pkg::S_BFIN: begin
                if (w_free) begin
                    o_ctl.build_fin = 1'b1;
                    w_load          = 1'b1;
                    n_state         = chb_pkg::S_IDLE;
                end
            end
            chb_pkg::S_SYM: begin
                if (w_free) begin
                    o_ctl.sym_emit = 1'b1;
                    w_load         = 1'b1;
                    n_state        = chb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = chb_pkg::S_IDLE;
            end
        endcase
        n_ov = w_load || (r_ov && i_out_stall);
    end

    assign o_in_stall  = !((r_state == chb_pkg::S_IDLE) && w_free);
    assign o_out_valid = r_ov;

endmodule

>>> rtl/core/canonical_huffman_bit_decoder.sv
// Channel  Direction  Handshake               Word
// in       input      i_in_valid/o_in_stall   i_in_data  (chb_pkg::t_chb_in)
// out      output     o_out_valid/i_out_stall o_out_data (chb_pkg::t_chb_out)
//
// Clear, load, append, unknown commands and decode bits that finish no code
// give their result word in the cycle after they are taken. A decode bit that
// completes a code passes S_SYM: the symbol comes from a registered read of
// the symbol memory. Build makes one pass over the lengths, one length a cycle.
// Reset (i_rst_n low, synchronous) clears counts, the walk and the built flag.
// A new word is taken while idle if the output register is empty or draining.
module canonical_huffman_bit_decoder #(
    parameter int MAX_CODE_LENGTH = chb_pkg::MAX_CODE_LENGTH_DEF,
    parameter int MAX_SYMBOLS     = chb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  chb_pkg::t_chb_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output chb_pkg::t_chb_out o_out_data
);

    chb_pkg::t_chb_ctl w_ctl;
    chb_pkg::t_chb_sts w_sts;

    chb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    chb_dpath #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
        .MAX_SYMBOLS     (MAX_SYMBOLS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

>>> rtl/core/chb_checker.sv
`include "canonical_huffman_bit_decoder_assert.svh"

module chb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input chb_pkg::t_chb_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input chb_pkg::t_chb_out o_out_data
);

    logic w_in_acc;
    logic w_quick;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_quick  = (i_in_data.cmd != chb_pkg::CMD_BUILD) &&
                      (i_in_data.cmd != chb_pkg::CMD_DECODE);

    `CHB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output word changed")
    `CHB_ASSERT_NOW(a_sym_ok, o_out_valid && o_out_data.symbol_valid, o_out_data.status == chb_pkg::STS_OK, "symbol with error status")
    `CHB_ASSERT_NOW(a_nosym_zero, o_out_valid && !o_out_data.symbol_valid, o_out_data.symbol == '0, "symbol not zero without a code")
    `CHB_ASSERT_NEXT(a_quick_result, w_in_acc && w_quick, o_out_valid, "set-up word gave no result next cycle")
    `CHB_ASSERT_NOW(a_status_code, o_out_valid, o_out_data.status == chb_pkg::STS_OK || o_out_data.status == chb_pkg::STS_NOT_BUILT || o_out_data.status == chb_pkg::STS_MISMATCH || o_out_data.status == chb_pkg::STS_OVERSUB || o_out_data.status == chb_pkg::STS_BAD_PATH, "status out of range")

endmodule

bind canonical_huffman_bit_decoder chb_checker u_chk (.*);

>>> tb/canonical_huffman_bit_decoder_checker.sv
`timescale 1ns / 100ps

module canonical_huffman_bit_decoder_checker
    import chb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_chb_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_chb_out i_out_data,
    output int       o_fail_count,
    output int       o_pending
);

    logic [7:0]  len_count  [16];
    logic [7:0]  sym_mem    [256];
    logic [8:0]  n_loaded;
    logic [16:0] first_code [16];
    logic [8:0]  val_offset [16];
    logic [16:0] code_end   [16];
    logic [15:0] walk_code;
    logic [4:0]  walk_depth;
    logic        built;
    t_chb_out    expected_words [$];
    t_chb_out    want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void return_to_root();
        walk_code  = '0;
        walk_depth = '0;
    endfunction

    function automatic logic [2:0] build_tables();
        int i;
        int sum;
        int code;
        int off;
        int fin;
        sum  = 0;
        code = 0;
        off  = 0;
        built = 1'b0;
        return_to_root();
        for (i = 0; i < 16; i++)
            sum += int'(len_count[i]);
        if (sum != int'(n_loaded))
            return STS_MISMATCH;
        for (i = 0; i < 16; i++) begin
            fin = code + int'(len_count[i]);
            if (fin > (1 << (i + 1)))
                return STS_OVERSUB;
            first_code[i] = code[16:0];
            val_offset[i] = off[8:0];
            code_end[i]   = fin[16:0];
            off  += int'(len_count[i]);
            code  = fin << 1;
        end
        built = 1'b1;
        return STS_OK;
    endfunction

    function automatic t_chb_out shift_in_bit(input logic b);
        t_chb_out r;
        int i;
        int top;
        int depth;
        int li;
        int idx;
        r = '0;
        r.status = STS_OK;
        if (!built) begin
            r.status = STS_NOT_BUILT;
            return r;
        end
        top = 0;
        for (i = 0; i < 16; i++)
            if (len_count[i] != '0)
                top = i + 1;
        walk_code  = {walk_code[14:0], b};
        walk_depth = walk_depth + 5'd1;
        depth = int'(walk_depth);
        if (top == 0 || depth > top) begin
            return_to_root();
            r.status = STS_BAD_PATH;
        end else begin
            li = depth - 1;
            if (len_count[li] != '0 && int'(walk_code) >= int'(first_code[li]) &&
                int'(walk_code) < int'(code_end[li])) begin
                idx = (int'(val_offset[li]) + int'(walk_code) - int'(first_code[li])) & 255;
                r.symbol_valid = 1'b1;
                r.symbol       = sym_mem[idx];
                return_to_root();
            end else if ((int'(walk_code) << (top - depth)) >= int'(code_end[top - 1])) begin
                // no longer a prefix of any longer code
                return_to_root();
                r.status = STS_BAD_PATH;
            end
        end
        return r;
    endfunction

    function automatic t_chb_out apply_word(input t_chb_in w);
        t_chb_out r;
        int i;
        r = '0;
        r.status = STS_OK;
        case (w.cmd)
            CMD_CLEAR: begin
                for (i = 0; i < 16; i++)
                    len_count[i] = '0;
                n_loaded = '0;
                built    = 1'b0;
                return_to_root();
            end
            CMD_LOAD: begin
                len_count[w.length_index] = w.count;
                built = 1'b0;
                return_to_root();
            end
            CMD_APPEND: begin
                if (int'(n_loaded) < MAX_SYMBOLS_DEF) begin
                    sym_mem[n_loaded[7:0]] = w.symbol_in;
                    n_loaded = n_loaded + 9'd1;
                    built    = 1'b0;
                    return_to_root();
                end else begin
                    r.status = STS_MISMATCH;
                end
            end
            CMD_BUILD: r.status = build_tables();
            CMD_DECODE: r = shift_in_bit(w.bit_req);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                len_count[i]  = '0;
                first_code[i] = '0;
                val_offset[i] = '0;
                code_end[i]   = '0;
            end
            n_loaded = '0;
            built    = 1'b0;
            return_to_root();
            expected_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(apply_word(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: valid %0d symbol %0d status %0d",
                           i_out_data.symbol_valid, i_out_data.symbol, i_out_data.status);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_data.symbol_valid !== want.symbol_valid) begin
                        $error("symbol_valid: expected %0d, got %0d",
                               want.symbol_valid, i_out_data.symbol_valid);
                        o_fail_count++;
                    end
                    if (i_out_data.symbol !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol, i_out_data.symbol);
                        o_fail_count++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_data.status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> tb/canonical_huffman_bit_decoder_tb.sv
`timescale 1ns / 100ps

module canonical_huffman_bit_decoder_tb;
    import chb_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 1000;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int SHAPE_RANDOM = 0;
    localparam int SHAPE_CHAIN  = 1;
    localparam int SHAPE_FULL   = 2;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_chb_in  in_word;
    logic     out_valid;
    logic     out_stall;
    t_chb_out out_word;
    int       fail_count;
    int       pending;

    int          set_count [16];
    int          set_n;
    logic [15:0] set_code [256];
    int          set_len  [256];
    logic [7:0]  set_sym  [256];

    bit quiet;
    int words_counted;
    int outs_seen;
    int cycle_count;

    always #HALF_PERIOD clk = ~clk;

    canonical_huffman_bit_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word)
    );

    canonical_huffman_bit_decoder_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_chb_in noisy_word(input logic [2:0] c);
        t_chb_in w;
        w.cmd          = c;
        w.length_index = 4'($urandom_range(0, 15));
        w.count        = 8'($urandom_range(0, 255));
        w.symbol_in    = 8'($urandom_range(0, 255));
        w.bit_req      = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic send_word(input t_chb_in w);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        do @(posedge clk); while (in_stall);
        if (w.cmd <= CMD_DECODE)
            words_counted++;
    endtask

    task automatic send_cmd(input logic [2:0] c);
        send_word(noisy_word(c));
    endtask

    task automatic load_count(input int li, input int cnt);
        t_chb_in w;
        w = noisy_word(CMD_LOAD);
        w.length_index = 4'(li);
        w.count        = 8'(cnt);
        send_word(w);
    endtask

    task automatic append_symbol(input logic [7:0] sv);
        t_chb_in w;
        w = noisy_word(CMD_APPEND);
        w.symbol_in = sv;
        send_word(w);
    endtask

    task automatic decode_bit(input logic b);
        t_chb_in w;
        w = noisy_word(CMD_DECODE);
        w.bit_req = b;
        send_word(w);
    endtask

    // Pick code lengths that fit the code space, then assign canonical codes.
    task automatic draw_code_set(input int shape);
        int i;
        int j;
        int len;
        int avail;
        int left;
        int top_len;
        int c;
        int code;
        int k;
        int r;
        for (i = 0; i < 16; i++)
            set_count[i] = 0;
        if (shape == SHAPE_CHAIN) begin
            for (i = 0; i < 15; i++)
                set_count[i] = 1;
            set_count[15] = 2;
        end else if (shape == SHAPE_FULL) begin
            set_count[7] = 255;
            set_count[8] = 1;
        end else begin
            r = $urandom_range(0, 9);
            top_len = (r < 7) ? $urandom_range(1, 6) :
                      (r < 9) ? $urandom_range(7, 12) : $urandom_range(13, 16);
            left  = $urandom_range(1, 20);
            avail = 2;
            for (len = 1; len <= top_len; len++) begin
                c = (avail < left) ? avail : left;
                if (len < top_len)
                    c = $urandom_range(0, c);
                else if (avail <= 40 && $urandom_range(0, 2) == 0)
                    c = avail;
                if (c > 255)
                    c = 255;
                set_count[len - 1] = c;
                left  = (left > c) ? left - c : 0;
                avail = (avail - c) * 2;
            end
        end
        code = 0;
        k    = 0;
        for (len = 1; len <= 16; len++) begin
            for (j = 0; j < set_count[len - 1]; j++) begin
                set_code[k] = code[15:0];
                set_len[k]  = len;
                set_sym[k]  = 8'($urandom_range(0, 255));
                k++;
                code++;
            end
            code = code * 2;
        end
        set_n = k;
    endtask

    task automatic program_code_set(input int appends);
        int pass;
        int i;
        int k;
        int start;
        bit loads_first;
        send_cmd(CMD_CLEAR);
        loads_first = 1'($urandom_range(0, 1));
        start = $urandom_range(0, 15);
        for (pass = 0; pass < 2; pass++) begin
            if ((pass == 0) == loads_first) begin
                for (i = 0; i < 16; i++)
                    if (set_count[(start + i) % 16] != 0 || $urandom_range(0, 5) == 0)
                        load_count((start + i) % 16, set_count[(start + i) % 16]);
            end else begin
                for (k = 0; k < appends; k++)
                    append_symbol(k < set_n ? set_sym[k] : 8'($urandom_range(0, 255)));
            end
        end
        send_cmd(CMD_BUILD);
    endtask

    // Mostly whole codewords of random symbols, some stray bits, rare rebuilds.
    task automatic decode_traffic(input int n);
        int i;
        int k;
        int b;
        int r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 85 && set_n > 0) begin
                k = $urandom_range(0, set_n - 1);
                for (b = set_len[k] - 1; b >= 0; b--)
                    decode_bit(set_code[k][b]);
            end else if (r < 97) begin
                repeat ($urandom_range(1, 4)) decode_bit(1'($urandom_range(0, 1)));
            end else begin
                send_cmd(CMD_BUILD);
            end
        end
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            outs_seen <= outs_seen + 1;

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("canonical_huffman_bit_decoder_tb: FAIL");
        $finish;
    end

    // Receiver: random stall runs, plus one long hold so the block backs up.
    initial begin
        int run;
        bit held_off;
        held_off  = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!held_off && outs_seen >= HOLD_AFTER) begin
                held_off  = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                run = pick_gap();
                if (run > 0) begin
                    out_stall = 1'b1;
                    repeat (run) @(negedge clk);
                end
            end
            out_stall = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    initial begin
        int seq;
        int kind;
        int li;
        int k;
        quiet         = 1'b0;
        outs_seen     = 0;
        words_counted = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        decode_bit(1'b0);
        send_cmd(CMD_SPARE_LO);
        send_cmd(CMD_SPARE_HI);
        send_cmd(CMD_BUILD);
        decode_bit(1'b1);
        load_count(15, 255);
        send_cmd(CMD_BUILD);
        send_cmd(CMD_CLEAR);
        load_count(0, 3);
        append_symbol(8'h00);
        append_symbol(8'hFF);
        append_symbol(8'h80);
        send_cmd(CMD_BUILD);
        decode_bit(1'b0);
        // lengths 1, 2, 3, 3: the code space is full, 111 is a valid code
        load_count(0, 1);
        load_count(1, 1);
        load_count(2, 2);
        append_symbol(8'h7F);
        send_cmd(CMD_BUILD);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b1);
        decode_bit(1'b1);
        // drop the walk mid-code with a set-up change
        decode_bit(1'b1);
        load_count(3, 0);

        words_counted = 0;
        seq = 0;
        while (words_counted < RANDOM_WORDS) begin
            quiet = ($urandom_range(0, 4) == 0);
            if (seq == 2) begin
                // all 256 entries, then one append past the end
                draw_code_set(SHAPE_FULL);
                program_code_set(set_n + 1);
                decode_traffic(20);
            end else begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0: repeat ($urandom_range(3, 10)) send_cmd(3'($urandom_range(0, 7)));
                    1: begin
                        case ($urandom_range(0, 2))
                            0: begin
                                draw_code_set(SHAPE_RANDOM);
                                program_code_set(set_n + 1);
                            end
                            1: begin
                                draw_code_set(SHAPE_RANDOM);
                                program_code_set(set_n - 1);
                            end
                            default: begin
                                for (k = 0; k < 16; k++)
                                    set_count[k] = 0;
                                li = $urandom_range(0, 3);
                                set_count[li] = (2 << li) + int'($urandom_range(1, 3));
                                set_n = set_count[li];
                                for (k = 0; k < set_n; k++)
                                    set_sym[k] = 8'($urandom_range(0, 255));
                                program_code_set(set_n);
                            end
                        endcase
                        decode_traffic($urandom_range(1, 3));
                    end
                    2: begin
                        draw_code_set(SHAPE_CHAIN);
                        program_code_set(set_n);
                        decode_traffic($urandom_range(10, 30));
                    end
                    default: begin
                        draw_code_set(SHAPE_RANDOM);
                        program_code_set(set_n);
                        decode_traffic($urandom_range(5, 30));
                    end
                endcase
            end
            seq++;
        end
        quiet = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("canonical_huffman_bit_decoder_tb: PASS");
        else
            $display("canonical_huffman_bit_decoder_tb: FAIL");
        $finish;
    end

endmodule
